@@ hw/rtl/lbc_pkg.sv @@
`default_nettype none

package lbc_pkg;

    // default sizes
    localparam int DEF_SLOT_COUNT = 32;
    localparam int DEF_COUNT_BITS = 8;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int SLOT_IN_W = 5;
    localparam int CNT_OUT_W = 8;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_GET     = 3'd0;
    localparam logic [OP_W-1:0] OP_RDGET   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_PIN     = 3'd3;
    localparam logic [OP_W-1:0] OP_UNPIN   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/lbc_ram.sv @@
`default_nettype none

module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/lbc_recency.sv @@
`default_nettype none

// recency kept as a rank per slot: rank 0 is most recent
module lbc_recency
    import lbc_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_move,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_move_slot,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_move_rank,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_rd_slot,
    output logic      [$clog2(SLOT_COUNT)-1:0] o_rd_rank
);

    localparam int SW = $clog2(SLOT_COUNT);

    logic [SW-1:0] r_rank [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!i_rst_n) begin
                r_rank[s] <= SW'(SLOT_COUNT - 1 - s);
            end else if (i_move) begin
                if (i_move_slot == SW'(s)) begin
                    r_rank[s] <= '0;
                end else if (r_rank[s] < i_move_rank) begin
                    r_rank[s] <= r_rank[s] + SW'(1);
                end
            end
        end
    end

    assign o_rd_rank = r_rank[i_rd_slot];

endmodule

`default_nettype wire

@@ hw/rtl/lru_block_buffer_cache_top.sv @@
// a get makes one pass of the entry memory read port over every slot in S_SCAN,
//   then S_GETUPD and S_DONE; release, pin and unpin step through S_SREAD, S_SUPD
//   and S_DONE, unknown or out of range items go straight to S_DONE
// one item at a time: the input stalls until the result is in the output register
// reset is synchronous: all tags zero, counts zero, slot SLOT_COUNT-1 most recent
`default_nettype none

module lru_block_buffer_cache_top
    import lbc_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [DEV_W-1:0]     i_device,
    input  wire logic [BLK_W-1:0]     i_block_number,
    input  wire logic [SLOT_IN_W-1:0] i_slot,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [SLOT_IN_W-1:0]      o_slot_out,
    output logic                      o_hit,
    output logic                      o_was_valid,
    output logic [CNT_OUT_W-1:0]      o_ref_count,
    output logic [STATUS_W-1:0]       o_status
);

    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int IDX_W  = SW + 1;
    localparam int VAL_B  = COUNT_BITS;
    localparam int BLK_LO = COUNT_BITS + 1;
    localparam int DEV_LO = BLK_LO + BLK_W;
    localparam int EW     = DEV_LO + DEV_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_GETUPD = 3'd2;
    localparam logic [2:0] S_SREAD  = 3'd3;
    localparam logic [2:0] S_SUPD   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [DEV_W-1:0]      r_dev, n_dev;
    logic [BLK_W-1:0]      r_blk, n_blk;
    logic [SW-1:0]         r_slot, n_slot;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [SW-1:0]         r_pend_slot, n_pend_slot;
    logic                  r_hit_f, n_hit_f;
    logic [SW-1:0]         r_hit_rank, n_hit_rank;
    logic [SW-1:0]         r_hit_slot, n_hit_slot;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic                  r_hit_val, n_hit_val;
    logic                  r_free_f, n_free_f;
    logic [SW-1:0]         r_free_rank, n_free_rank;
    logic [SW-1:0]         r_free_slot, n_free_slot;
    logic [SLOT_COUNT-1:0] r_written, n_written;
    logic [SLOT_IN_W-1:0]  r_res_slot, n_res_slot;
    logic                  r_res_hit, n_res_hit;
    logic                  r_res_was, n_res_was;
    logic [CNT_OUT_W-1:0]  r_res_cnt, n_res_cnt;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic                  r_o_valid, n_o_valid;
    logic [SLOT_IN_W-1:0]  r_o_slot, n_o_slot;
    logic                  r_o_hit, n_o_hit;
    logic                  r_o_was, n_o_was;
    logic [CNT_OUT_W-1:0]  r_o_cnt, n_o_cnt;
    logic [STATUS_W-1:0]   r_o_status, n_o_status;

    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [SW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_q;

    logic [SW-1:0]         rd_q_slot;
    logic                  e_written;
    logic [DEV_W-1:0]      e_dev;
    logic [BLK_W-1:0]      e_blk;
    logic                  e_val;
    logic [COUNT_BITS-1:0] e_cnt;
    logic [SW-1:0]         rank_q;
    logic                  move_en;
    logic                  e_match;
    logic                  in_range;
    logic                  is_mark;

    lbc_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    lbc_recency #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_recency (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_move      (move_en),
        .i_move_slot (r_slot),
        .i_move_rank (rank_q),
        .i_rd_slot   (rd_q_slot),
        .o_rd_rank   (rank_q)
    );

    // entry data returned this cycle belongs to rd_q_slot; never written reads as zero
    assign rd_q_slot = (r_state == S_SCAN) ? r_pend_slot : r_slot;
    assign e_written = r_written[rd_q_slot];
    assign e_dev     = e_written ? ram_q[DEV_LO +: DEV_W] : '0;
    assign e_blk     = e_written ? ram_q[BLK_LO +: BLK_W] : '0;
    assign e_val     = e_written ? ram_q[VAL_B] : 1'b0;
    assign e_cnt     = e_written ? ram_q[0 +: COUNT_BITS] : '0;
    assign e_match   = (e_dev == r_dev) && (e_blk == r_blk);
    assign in_range  = 32'(i_slot) < SLOT_COUNT;
    assign is_mark   = (r_op == OP_RDGET);

    assign ram_raddr = (r_state == S_SCAN) ? r_idx[SW-1:0] : r_slot;
    assign move_en   = (r_state == S_SUPD) && (r_op == OP_RELEASE) && (e_cnt == CNT_ONE);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_dev        = r_dev;
        n_blk        = r_blk;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pend_slot  = r_pend_slot;
        n_hit_f      = r_hit_f;
        n_hit_rank   = r_hit_rank;
        n_hit_slot   = r_hit_slot;
        n_hit_cnt    = r_hit_cnt;
        n_hit_val    = r_hit_val;
        n_free_f     = r_free_f;
        n_free_rank  = r_free_rank;
        n_free_slot  = r_free_slot;
        n_written    = r_written;
        n_res_slot   = r_res_slot;
        n_res_hit    = r_res_hit;
        n_res_was    = r_res_was;
        n_res_cnt    = r_res_cnt;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid && i_stall;
        n_o_slot     = r_o_slot;
        n_o_hit      = r_o_hit;
        n_o_was      = r_o_was;
        n_o_cnt      = r_o_cnt;
        n_o_status   = r_o_status;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = i_operation;
                    n_dev        = i_device;
                    n_blk        = i_block_number;
                    n_slot       = SW'(i_slot);
                    n_res_slot   = '0;
                    n_res_hit    = 1'b0;
                    n_res_was    = 1'b0;
                    n_res_cnt    = '0;
                    n_res_status = ST_OK;
                    case (i_operation) inside
                        OP_GET, OP_RDGET: begin
                            n_idx    = '0;
                            n_hit_f  = 1'b0;
                            n_free_f = 1'b0;
                            n_state  = S_SCAN;
                        end
                        OP_RELEASE, OP_PIN, OP_UNPIN: begin
                            if (in_range) begin
                                n_state = S_SREAD;
                            end else begin
                                n_res_slot = i_slot;
                                n_state    = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one slot read per cycle, compare it the next cycle
                if (r_idx < IDX_W'(SLOT_COUNT)) begin
                    n_pend      = 1'b1;
                    n_pend_slot = r_idx[SW-1:0];
                    n_idx       = r_idx + IDX_W'(1);
                end
                if (r_pend) begin
                    if (e_match && (!r_hit_f || rank_q < r_hit_rank)) begin
                        n_hit_f    = 1'b1;
                        n_hit_rank = rank_q;
                        n_hit_slot = r_pend_slot;
                        n_hit_cnt  = e_cnt;
                        n_hit_val  = e_val;
                    end
                    if (e_cnt == '0 && (!r_free_f || rank_q > r_free_rank)) begin
                        n_free_f    = 1'b1;
                        n_free_rank = rank_q;
                        n_free_slot = r_pend_slot;
                    end
                    if (r_pend_slot == SW'(SLOT_COUNT - 1)) begin
                        n_state = S_GETUPD;
                    end
                end
            end
            S_GETUPD: begin
                if (r_hit_f) begin
                    n_res_slot = SLOT_IN_W'(r_hit_slot);
                    n_res_hit  = 1'b1;
                    n_res_was  = r_hit_val;
                    if (r_hit_cnt == CNT_MAX) begin
                        n_res_cnt    = CNT_OUT_W'(r_hit_cnt);
                        n_res_status = ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hit_slot;
                        ram_wdata = {r_dev, r_blk, r_hit_val | is_mark, r_hit_cnt + CNT_ONE};
                        n_written[r_hit_slot] = 1'b1;
                        n_res_cnt = CNT_OUT_W'(r_hit_cnt + CNT_ONE);
                    end
                end else if (r_free_f) begin
                    // recycle the least recent unreferenced slot
                    ram_we    = 1'b1;
                    ram_waddr = r_free_slot;
                    ram_wdata = {r_dev, r_blk, is_mark, CNT_ONE};
                    n_written[r_free_slot] = 1'b1;
                    n_res_slot = SLOT_IN_W'(r_free_slot);
                    n_res_cnt  = CNT_OUT_W'(CNT_ONE);
                end else begin
                    n_res_status = ST_NO_FREE;
                end
                n_state = S_DONE;
            end
            S_SREAD: begin
                n_state = S_SUPD;
            end
            S_SUPD: begin
                n_res_slot = SLOT_IN_W'(r_slot);
                n_res_was  = e_val;
                ram_waddr  = r_slot;
                if (r_op == OP_PIN) begin
                    if (e_cnt == CNT_MAX) begin
                        n_res_cnt    = CNT_OUT_W'(e_cnt);
                        n_res_status = ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {e_dev, e_blk, e_val, e_cnt + CNT_ONE};
                        n_written[r_slot] = 1'b1;
                        n_res_cnt = CNT_OUT_W'(e_cnt + CNT_ONE);
                    end
                end else begin
                    if (e_cnt == '0) begin
                        n_res_status = ST_UNDERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {e_dev, e_blk, e_val, e_cnt - CNT_ONE};
                        n_written[r_slot] = 1'b1;
                        n_res_cnt = CNT_OUT_W'(e_cnt - CNT_ONE);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_slot   = r_res_slot;
                    n_o_hit    = r_res_hit;
                    n_o_was    = r_res_was;
                    n_o_cnt    = r_res_cnt;
                    n_o_status = r_res_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_hit_f   <= 1'b0;
            r_free_f  <= 1'b0;
            r_written <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_hit_f   <= n_hit_f;
            r_free_f  <= n_free_f;
            r_written <= n_written;
            r_o_valid <= n_o_valid;
            r_idx     <= n_idx;
        end
        r_op         <= n_op;
        r_dev        <= n_dev;
        r_blk        <= n_blk;
        r_slot       <= n_slot;
        r_pend_slot  <= n_pend_slot;
        r_hit_rank   <= n_hit_rank;
        r_hit_slot   <= n_hit_slot;
        r_hit_cnt    <= n_hit_cnt;
        r_hit_val    <= n_hit_val;
        r_free_rank  <= n_free_rank;
        r_free_slot  <= n_free_slot;
        r_res_slot   <= n_res_slot;
        r_res_hit    <= n_res_hit;
        r_res_was    <= n_res_was;
        r_res_cnt    <= n_res_cnt;
        r_res_status <= n_res_status;
        r_o_slot     <= n_o_slot;
        r_o_hit      <= n_o_hit;
        r_o_was      <= n_o_was;
        r_o_cnt      <= n_o_cnt;
        r_o_status   <= n_o_status;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_slot_out  = r_o_slot;
    assign o_hit       = r_o_hit;
    assign o_was_valid = r_o_was;
    assign o_ref_count = r_o_cnt;
    assign o_status    = r_o_status;

    a_no_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NO_FREE |-> o_slot_out == '0 && !o_hit && o_ref_count == '0)
        else $error("no free slot result carries nonzero fields");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_status == ST_OK || o_status == ST_OVERFLOW)
        else $error("hit with underflow or no free slot status");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_GETUPD || r_state == S_SUPD)
        else $error("entry write outside an update step");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> r_state == S_GETUPD || r_idx <= IDX_W'(SLOT_COUNT))
        else $error("scan index ran past the last slot");

endmodule

`default_nettype wire

@@ tb/lbc_cache_checker.sv @@
module lbc_cache_checker
    import lbc_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [DEV_W-1:0]     i_device,
    input  wire logic [BLK_W-1:0]     i_block_number,
    input  wire logic [SLOT_IN_W-1:0] i_slot,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [SLOT_IN_W-1:0] i_slot_out,
    input  wire logic                 i_hit,
    input  wire logic                 i_was_valid,
    input  wire logic [CNT_OUT_W-1:0] i_ref_count,
    input  wire logic [STATUS_W-1:0]  i_status,
    input  wire logic                 i_end_check,
    output int                        o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot_out;
        logic                 hit;
        logic                 was_valid;
        logic [CNT_OUT_W-1:0] ref_count;
        logic [STATUS_W-1:0]  status;
    } t_cache_result;

    logic [DEV_W-1:0]      tag_dev  [SLOT_COUNT];
    logic [BLK_W-1:0]      tag_blk  [SLOT_COUNT];
    logic                  filled   [SLOT_COUNT];
    logic [COUNT_BITS-1:0] refs     [SLOT_COUNT];
    int                    lru_list [SLOT_COUNT];   // position 0 is the most recent slot
    t_cache_result         expected_q [$];

    int   fail_count = 0;
    int   accepted = 0;
    int   hits = 0;
    int   refills = 0;
    int   no_free = 0;
    int   underflows = 0;
    int   overflows = 0;
    logic summary_done = 1'b0;

    assign o_fail_count = fail_count;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        if (fail_count < 25)
            $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic t_cache_result predict_access(
        input logic [OP_W-1:0]      op,
        input logic [DEV_W-1:0]     dev,
        input logic [BLK_W-1:0]     blk,
        input logic [SLOT_IN_W-1:0] sl
    );
        t_cache_result r;
        int way;
        int pos;
        r = '0;
        way = -1;
        pos = 0;
        if (op == OP_GET || op == OP_RDGET) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (way < 0 && tag_dev[lru_list[i]] == dev && tag_blk[lru_list[i]] == blk)
                    way = lru_list[i];
            if (way >= 0) begin
                r.slot_out  = SLOT_IN_W'(way);
                r.hit       = 1'b1;
                r.was_valid = filled[way];
                if (refs[way] == COUNT_MAX) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    refs[way]++;
                    if (op == OP_RDGET)
                        filled[way] = 1'b1;
                end
                r.ref_count = CNT_OUT_W'(refs[way]);
            end else begin
                // recycle the least recent slot nobody holds
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (way < 0 && refs[lru_list[i]] == '0)
                        way = lru_list[i];
                if (way < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    tag_dev[way] = dev;
                    tag_blk[way] = blk;
                    filled[way]  = (op == OP_RDGET);
                    refs[way]    = COUNT_BITS'(1);
                    r.slot_out   = SLOT_IN_W'(way);
                    r.ref_count  = CNT_OUT_W'(1);
                end
            end
        end else if (op == OP_RELEASE || op == OP_PIN || op == OP_UNPIN) begin
            r.slot_out = sl;
            if (int'(sl) < SLOT_COUNT) begin
                r.was_valid = filled[sl];
                if (op == OP_PIN) begin
                    if (refs[sl] == COUNT_MAX)
                        r.status = ST_OVERFLOW;
                    else
                        refs[sl]++;
                end else if (refs[sl] == '0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    refs[sl]--;
                    // a release that frees the slot makes it most recent, an unpin does not
                    if (op == OP_RELEASE && refs[sl] == '0) begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                            if (lru_list[i] == int'(sl))
                                pos = i;
                        for (int i = pos; i > 0; i--)
                            lru_list[i] = lru_list[i - 1];
                        lru_list[0] = int'(sl);
                    end
                end
                r.ref_count = CNT_OUT_W'(refs[sl]);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cache_result got;
        t_cache_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                tag_dev[i]  = '0;
                tag_blk[i]  = '0;
                filled[i]   = 1'b0;
                refs[i]     = '0;
                lru_list[i] = SLOT_COUNT - 1 - i;
            end
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_slot_out, i_hit, i_was_valid, i_ref_count, i_status};
                if (expected_q.size() == 0) begin
                    report("result with nothing pending", 32'(got), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.slot_out != want.slot_out)
                        report("slot_out", 32'(got.slot_out), 32'(want.slot_out));
                    if (got.hit != want.hit)
                        report("hit", 32'(got.hit), 32'(want.hit));
                    if (got.was_valid != want.was_valid)
                        report("was_valid", 32'(got.was_valid), 32'(want.was_valid));
                    if (got.ref_count != want.ref_count)
                        report("ref_count", 32'(got.ref_count), 32'(want.ref_count));
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = predict_access(i_operation, i_device, i_block_number, i_slot);
                expected_q.push_back(want);
                accepted++;
                if (want.hit)
                    hits++;
                else if ((i_operation == OP_GET || i_operation == OP_RDGET)
                         && want.status == ST_OK)
                    refills++;
                case (want.status)
                    ST_NO_FREE:   no_free++;
                    ST_UNDERFLOW: underflows++;
                    ST_OVERFLOW:  overflows++;
                    default: ;
                endcase
            end
            if (i_end_check && !summary_done) begin
                summary_done = 1'b1;
                if (expected_q.size() != 0)
                    report("results never delivered", expected_q.size(), 0);
                $display("cache run: %0d items, %0d hits, %0d refills, %0d gets with no free slot",
                         accepted, hits, refills, no_free);
                $display("cache run: %0d count underflows, %0d count overflows, %0d mismatches",
                         underflows, overflows, fail_count);
            end
        end
    end

endmodule

@@ tb/tb_lru_block_buffer_cache_top.sv @@
module tb_lru_block_buffer_cache_top
    import lbc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT   = DEF_SLOT_COUNT;
    localparam int COUNT_BITS   = DEF_COUNT_BITS;
    localparam int CLK_PERIOD   = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = SLOT_COUNT + 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OP_W-1:0]      i_operation;
    logic [DEV_W-1:0]     i_device;
    logic [BLK_W-1:0]     i_block_number;
    logic [SLOT_IN_W-1:0] i_slot;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [SLOT_IN_W-1:0] o_slot_out;
    logic                 o_hit;
    logic                 o_was_valid;
    logic [CNT_OUT_W-1:0] o_ref_count;
    logic [STATUS_W-1:0]  o_status;

    logic                 end_check;
    int                   fail_count;
    int                   items_sent = 0;
    int                   results_seen = 0;
    logic [SLOT_IN_W-1:0] last_slot = '0;
    logic [STATUS_W-1:0]  last_status = ST_OK;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    lru_block_buffer_cache_top #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_slot_out     (o_slot_out),
        .o_hit          (o_hit),
        .o_was_valid    (o_was_valid),
        .o_ref_count    (o_ref_count),
        .o_status       (o_status)
    );

    lbc_cache_checker #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) cache_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_operation    (i_operation),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_slot_out     (o_slot_out),
        .i_hit          (o_hit),
        .i_was_valid    (o_was_valid),
        .i_ref_count    (o_ref_count),
        .i_status       (o_status),
        .i_end_check    (end_check),
        .o_fail_count   (fail_count)
    );

    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    // the last result tells the stimulus which slot a get landed on
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            last_slot    <= o_slot_out;
            last_status  <= o_status;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles", IDLE_LIMIT);
            $display("** lru_block_buffer_cache_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // small tag pool so gets hit as well as miss
    function automatic logic [DEV_W-1:0] random_device();
        return $urandom_range(1) ? DEV_W'($urandom_range(1)) : DEV_W'($urandom);
    endfunction

    function automatic logic [BLK_W-1:0] random_block();
        return $urandom_range(3) ? BLK_W'($urandom_range(15)) : BLK_W'($urandom);
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]      op,
        input logic [DEV_W-1:0]     dev,
        input logic [BLK_W-1:0]     blk,
        input logic [SLOT_IN_W-1:0] sl
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_device       <= dev;
        i_block_number <= blk;
        i_slot         <= sl;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (results_seen != items_sent);
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct, input int n_items);
        int stop_at;
        int kind;
        int pick;
        logic [OP_W-1:0] op;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(9);
            if (kind < 5) begin
                repeat (10) begin
                    pick = $urandom_range(99);
                    if (pick < 25)
                        op = OP_GET;
                    else if (pick < 45)
                        op = OP_RDGET;
                    else if (pick < 75)
                        op = OP_RELEASE;
                    else if (pick < 85)
                        op = OP_PIN;
                    else if (pick < 97)
                        op = OP_UNPIN;
                    else
                        op = OP_W'($urandom_range(OP_UNPIN + 1, (1 << OP_W) - 1));
                    send_item(op, random_device(), random_block(),
                              SLOT_IN_W'($urandom_range(SLOT_COUNT - 1)));
                end
            end else if (kind == 5) begin
                // more fresh tags than slots, runs out of free slots
                repeat (SLOT_COUNT + 2)
                    send_item($urandom_range(1) ? OP_RDGET : OP_GET, DEV_W'($urandom),
                              BLK_W'($urandom), SLOT_IN_W'($urandom));
            end else if (kind == 6) begin
                repeat (48)
                    send_item($urandom_range(3) ? OP_RELEASE : OP_UNPIN, DEV_W'($urandom),
                              BLK_W'($urandom), SLOT_IN_W'($urandom_range(SLOT_COUNT - 1)));
            end else if (kind < 9) begin
                // get, then release the slot it returned
                repeat (8) begin
                    send_item($urandom_range(1) ? OP_RDGET : OP_GET, random_device(),
                              random_block(), SLOT_IN_W'($urandom));
                    wait_results();
                    send_item(OP_RELEASE, DEV_W'($urandom), BLK_W'($urandom), last_slot);
                end
            end else begin
                repeat (6)
                    send_item(OP_W'($urandom), DEV_W'($urandom), BLK_W'($urandom),
                              SLOT_IN_W'($urandom));
            end
        end
    endtask

    // drive one slot's count to saturation and back down through zero
    task automatic saturate_one_slot();
        logic [DEV_W-1:0]     dev;
        logic [BLK_W-1:0]     blk;
        logic [SLOT_IN_W-1:0] target;
        int                   tries;
        dev   = DEV_W'($urandom);
        blk   = BLK_W'($urandom);
        tries = 0;
        send_item(OP_GET, dev, blk, SLOT_IN_W'($urandom));
        wait_results();
        while (last_status == ST_NO_FREE && tries < 8) begin
            for (int k = 0; k < SLOT_COUNT; k++)
                send_item(OP_RELEASE, DEV_W'($urandom), BLK_W'($urandom), SLOT_IN_W'(k));
            send_item(OP_GET, dev, blk, SLOT_IN_W'($urandom));
            wait_results();
            tries++;
        end
        target = last_slot;
        repeat (1 << COUNT_BITS)
            send_item(OP_PIN, DEV_W'($urandom), BLK_W'($urandom), target);
        // saturated: hits change nothing and a read-get leaves the slot unfilled
        send_item(OP_GET, dev, blk, SLOT_IN_W'($urandom));
        send_item(OP_RDGET, dev, blk, SLOT_IN_W'($urandom));
        send_item(OP_GET, dev, blk, SLOT_IN_W'($urandom));
        repeat (1 << COUNT_BITS)
            send_item(OP_RELEASE, DEV_W'($urandom), BLK_W'($urandom), target);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_operation    <= OP_GET;
        i_device       <= '0;
        i_block_number <= '0;
        i_slot         <= '0;
        end_check      <= 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 50;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every slot starts tagged device 0 block 0
        send_item(OP_GET, 8'h00, 32'h0000_0000, 5'd0);
        send_item(OP_RDGET, 8'h00, 32'h0000_0000, 5'd31);
        send_item(OP_GET, 8'h00, 32'h0000_0000, 5'd0);
        send_item(OP_RDGET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_item(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_GET, 8'hAA, 32'h5555_5555, 5'd31);
        // release to zero moves slot 1 to the front, second release underflows
        send_item(OP_RELEASE, 8'h55, 32'hAAAA_AAAA, 5'd1);
        send_item(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1);
        send_item(OP_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd2);
        send_item(OP_PIN, 8'h00, 32'h0000_0000, 5'd2);
        // unpin to zero keeps slot 2 in place, so the next miss takes it
        send_item(OP_UNPIN, 8'hAA, 32'h5555_5555, 5'd2);
        send_item(OP_GET, 8'h55, 32'hAAAA_AAAA, 5'd0);
        send_item(OP_PIN, 8'h00, 32'h0000_0000, 5'd31);
        send_item(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
        send_item(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
        for (int op = OP_UNPIN + 1; op < (1 << OP_W); op++)
            send_item(OP_W'(op), 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_item(OP_GET, 8'h00, 32'h0000_0000, 5'd0);
        send_item(OP_RELEASE, 8'hFF, 32'h0000_0000, 5'd31);

        run_phase(18, 50, 350);
        run_phase(50, 18, 350);
        run_phase(0, 0, 200);
        saturate_one_slot();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("** lru_block_buffer_cache_top: PASSED **");
        else
            $display("** lru_block_buffer_cache_top: FAILED **");
        $finish;
    end

endmodule

@@ lru_block_buffer_cache_top.f @@
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_ram.sv
hw/rtl/lbc_recency.sv
hw/rtl/lru_block_buffer_cache_top.sv
tb/lbc_cache_checker.sv
tb/tb_lru_block_buffer_cache_top.sv
